// ----- design/qnl_pkg.sv -----
package qnl_pkg;

    localparam int ONE       = 16384;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 16;
    localparam int SR_W      = 36;
    localparam int REM_W     = 50;
    localparam int DVS_W     = 34;
    localparam int NSTG      = 3 + SQ_STEPS + 1 + DIV_STEPS + 4 + SQ_STEPS + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic [SR_W-1:0] rem;
        logic [31:0]     root;
    } sq_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [15:0]      q;
    } dv_t;

    typedef struct packed {
        logic [3:0][15:0] p;
        logic [3:0][15:0] q;
        logic [14:0]      t;
        logic             dneg;
        logic             zero;
    } inp_t;

    typedef struct packed {
        sq_t         s1;
        sq_t         s2;
        logic [63:0] n1;
        logic [63:0] n2;
        inp_t        d;
    } sqa_t;

    typedef struct packed {
        dv_t [7:0]             dv;
        logic [1:0][DVS_W-1:0] dvs;
        logic [7:0]            neg;
        logic [14:0]           t;
        logic                  dneg;
        logic                  zero;
    } dva_t;

    typedef struct packed {
        sq_t              s;
        logic [63:0]      n;
        logic [3:0][28:0] mag;
        logic [3:0]       neg;
        logic             zero;
    } sqb_t;

    typedef struct packed {
        dv_t [3:0]        dv;
        logic [DVS_W-1:0] dvs;
        logic [3:0]       neg;
        logic             zero;
    } dvb_t;

    // one root bit per step
    function automatic sq_t sq_step(sq_t s, logic [1:0] nb);
        sq_t             o;
        logic [SR_W-1:0] r;
        logic [SR_W-1:0] tr;
        r  = {s.rem[SR_W-3:0], nb};
        tr = {2'b00, s.root, 2'b01};
        if (r >= tr)
        begin
            o.rem  = r - tr;
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // restoring division, one quotient bit per step, bit k
    function automatic dv_t dv_step(dv_t d, logic [DVS_W-1:0] dvs, int k);
        dv_t              o;
        logic [REM_W-1:0] sh;
        sh = REM_W'(dvs) << k;
        if (d.rem >= sh)
        begin
            o.rem = d.rem - sh;
            o.q   = {d.q[14:0], 1'b1};
        end
        else
        begin
            o.rem = d.rem;
            o.q   = {d.q[14:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [15:0] sat_q(logic [15:0] q, logic neg);
        logic [15:0] m;
        m = (q > 16'(ONE)) ? 16'(ONE) : q;
        return neg ? 16'(-m) : m;
    endfunction

    function automatic logic [15:0] mag16(logic [15:0] x);
        return x[15] ? 16'(-x) : x;
    endfunction

endpackage

// ----- design/quaternion_nlerp.sv -----
// Normalized shortest-path blend of two Q2.14 quaternions by a Q1.14 weight.
// Fully pipelined: one item accepted per cycle unless the pipeline stalls;
// the path runs through two 32-step square-root pipelines and two 16-step
// division pipelines. The whole pipeline stalls while the result is not
// taken. A zero-length input or blend sets zero_length and gives zero.
module quaternion_nlerp
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // q1_x,q1_y,q1_z,q1_w,q2_x,q2_y,q2_z,q2_w,blend[14:0],pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // res_x,res_y,res_z,res_w
    output logic         m_tuser   // zero_length
);
    import qnl_pkg::*;

    logic                adv;
    logic [NSTG-1:0]     vld_reg;

    logic [3:0][15:0]    p0_reg, q0_reg;
    logic [14:0]         t0_reg;
    logic [3:0][31:0]    sp1_reg, sq1_reg, dp1_reg;
    logic [3:0][15:0]    p1_reg, q1_reg;
    logic [14:0]         t1_reg;
    sqa_t                sqa_reg [0:SQ_STEPS];
    sqa_t                sqa_next;
    dva_t                dva_reg [0:DIV_STEPS];
    dva_t                dva_next;
    logic [3:0][31:0]    pa_reg, pb_reg;
    logic                z2_reg;
    logic [3:0][29:0]    v_reg;
    logic                z3_reg;
    logic [3:0][57:0]    vv_reg;
    logic [3:0][28:0]    vm_reg;
    logic [3:0]          vn_reg;
    logic                z4_reg;
    sqb_t                sqb_reg [0:SQ_STEPS];
    sqb_t                sqb_next;
    dvb_t                dvb_reg [0:DIV_STEPS];
    dvb_t                dvb_next;
    logic [63:0]         res_reg;
    logic                zl_reg;

    logic [3:0][31:0]    pa_next, pb_next;
    logic [3:0][29:0]    v_next;
    logic [63:0]         res_next;

    assign adv      = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = res_reg;
    assign m_tuser  = zl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
    end

    always_comb
    begin
        logic [33:0] s1, s2;
        logic [33:0] dot;
        s1  = '0;
        s2  = '0;
        dot = '0;
        for (int i = 0; i < 4; i++)
        begin
            s1  = s1 + 34'(sp1_reg[i]);
            s2  = s2 + 34'(sq1_reg[i]);
            dot = dot + 34'($signed(dp1_reg[i]));
        end
        sqa_next.s1     = '0;
        sqa_next.s2     = '0;
        sqa_next.n1     = {2'b00, s1, 28'b0};
        sqa_next.n2     = {2'b00, s2, 28'b0};
        sqa_next.d.p    = p1_reg;
        sqa_next.d.q    = q1_reg;
        sqa_next.d.t    = t1_reg;
        sqa_next.d.dneg = dot[33];
        sqa_next.d.zero = (s1 == '0) || (s2 == '0);
    end

    always_comb
    begin
        logic [31:0] l1, l2;
        l1 = sqa_reg[SQ_STEPS].s1.root;
        l2 = sqa_reg[SQ_STEPS].s2.root;
        dva_next.dvs[0] = DVS_W'({l1, 1'b0});
        dva_next.dvs[1] = DVS_W'({l2, 1'b0});
        for (int i = 0; i < 4; i++)
        begin
            dva_next.dv[i].rem   = REM_W'({mag16(sqa_reg[SQ_STEPS].d.p[i]), 29'b0})
                                 + REM_W'(l1);
            dva_next.dv[i].q     = '0;
            dva_next.dv[i+4].rem = REM_W'({mag16(sqa_reg[SQ_STEPS].d.q[i]), 29'b0})
                                 + REM_W'(l2);
            dva_next.dv[i+4].q   = '0;
            dva_next.neg[i]      = sqa_reg[SQ_STEPS].d.p[i][15];
            dva_next.neg[i+4]    = sqa_reg[SQ_STEPS].d.q[i][15];
        end
        dva_next.t    = sqa_reg[SQ_STEPS].d.t;
        dva_next.dneg = sqa_reg[SQ_STEPS].d.dneg;
        dva_next.zero = sqa_reg[SQ_STEPS].d.zero;
    end

    always_comb
    begin
        logic [15:0] a, b;
        logic [14:0] omt;
        omt = 15'(ONE) - dva_reg[DIV_STEPS].t;
        for (int i = 0; i < 4; i++)
        begin
            a = sat_q(dva_reg[DIV_STEPS].dv[i].q, dva_reg[DIV_STEPS].neg[i]);
            b = sat_q(dva_reg[DIV_STEPS].dv[i+4].q,
                      dva_reg[DIV_STEPS].neg[i+4] ^ dva_reg[DIV_STEPS].dneg);
            pa_next[i] = 32'($signed(a) * $signed({1'b0, omt}));
            pb_next[i] = 32'($signed(b) * $signed({1'b0, dva_reg[DIV_STEPS].t}));
            v_next[i]  = 30'($signed(pa_reg[i]) + $signed(pb_reg[i]));
        end
    end

    always_comb
    begin
        logic [59:0] s;
        s = '0;
        for (int i = 0; i < 4; i++)
            s = s + 60'(vv_reg[i]);
        sqb_next.s    = '0;
        sqb_next.n    = {s, 4'b0};
        sqb_next.mag  = vm_reg;
        sqb_next.neg  = vn_reg;
        sqb_next.zero = z4_reg;
    end

    always_comb
    begin
        logic [31:0] l;
        l = sqb_reg[SQ_STEPS].s.root;
        dvb_next.dvs = DVS_W'({l, 1'b0});
        for (int i = 0; i < 4; i++)
        begin
            dvb_next.dv[i].rem = REM_W'({sqb_reg[SQ_STEPS].mag[i], 17'b0}) + REM_W'(l);
            dvb_next.dv[i].q   = '0;
        end
        dvb_next.neg  = sqb_reg[SQ_STEPS].neg;
        dvb_next.zero = sqb_reg[SQ_STEPS].zero;
        for (int i = 0; i < 4; i++)
            res_next[16*i +: 16] = dvb_reg[DIV_STEPS].zero ? 16'd0 :
                sat_q(dvb_reg[DIV_STEPS].dv[i].q, dvb_reg[DIV_STEPS].neg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                p0_reg[i] <= s_tdata[16*i +: 16];
                q0_reg[i] <= s_tdata[64 + 16*i +: 16];
            end
            t0_reg <= (s_tdata[142:128] > 15'(ONE)) ? 15'(ONE) : s_tdata[142:128];

            for (int i = 0; i < 4; i++)
            begin
                sp1_reg[i] <= 32'($signed(p0_reg[i]) * $signed(p0_reg[i]));
                sq1_reg[i] <= 32'($signed(q0_reg[i]) * $signed(q0_reg[i]));
                dp1_reg[i] <= 32'($signed(p0_reg[i]) * $signed(q0_reg[i]));
            end
            p1_reg <= p0_reg;
            q1_reg <= q0_reg;
            t1_reg <= t0_reg;

            sqa_reg[0] <= sqa_next;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sqa_reg[k+1].n1 <= sqa_reg[k].n1;
                sqa_reg[k+1].n2 <= sqa_reg[k].n2;
                sqa_reg[k+1].d  <= sqa_reg[k].d;
                sqa_reg[k+1].s1 <= sq_step(sqa_reg[k].s1, sqa_reg[k].n1[63-2*k -: 2]);
                sqa_reg[k+1].s2 <= sq_step(sqa_reg[k].s2, sqa_reg[k].n2[63-2*k -: 2]);
            end

            dva_reg[0] <= dva_next;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dva_reg[k+1].dvs  <= dva_reg[k].dvs;
                dva_reg[k+1].neg  <= dva_reg[k].neg;
                dva_reg[k+1].t    <= dva_reg[k].t;
                dva_reg[k+1].dneg <= dva_reg[k].dneg;
                dva_reg[k+1].zero <= dva_reg[k].zero;
                for (int i = 0; i < 8; i++)
                    dva_reg[k+1].dv[i] <= dv_step(dva_reg[k].dv[i],
                        dva_reg[k].dvs[i/4], DIV_STEPS-1-k);
            end

            pa_reg <= pa_next;
            pb_reg <= pb_next;
            z2_reg <= dva_reg[DIV_STEPS].zero;

            v_reg  <= v_next;
            z3_reg <= z2_reg || (v_next == '0);

            for (int i = 0; i < 4; i++)
            begin
                vm_reg[i] <= v_reg[i][29] ? 29'(-$signed(v_reg[i])) : v_reg[i][28:0];
                vn_reg[i] <= v_reg[i][29];
                vv_reg[i] <= 58'($signed(v_reg[i]) * $signed(v_reg[i]));
            end
            z4_reg <= z3_reg;

            sqb_reg[0] <= sqb_next;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sqb_reg[k+1].n    <= sqb_reg[k].n;
                sqb_reg[k+1].mag  <= sqb_reg[k].mag;
                sqb_reg[k+1].neg  <= sqb_reg[k].neg;
                sqb_reg[k+1].zero <= sqb_reg[k].zero;
                sqb_reg[k+1].s    <= sq_step(sqb_reg[k].s, sqb_reg[k].n[63-2*k -: 2]);
            end

            dvb_reg[0] <= dvb_next;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dvb_reg[k+1].dvs  <= dvb_reg[k].dvs;
                dvb_reg[k+1].neg  <= dvb_reg[k].neg;
                dvb_reg[k+1].zero <= dvb_reg[k].zero;
                for (int i = 0; i < 4; i++)
                    dvb_reg[k+1].dv[i] <= dv_step(dvb_reg[k].dv[i],
                        dvb_reg[k].dvs, DIV_STEPS-1-k);
            end

            res_reg <= res_next;
            zl_reg  <= dvb_reg[DIV_STEPS].zero;
        end
    end

    a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("zero_length item with nonzero result");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) >= -16384) && ($signed(m_tdata[15:0]) <= 16384)
                  && ($signed(m_tdata[63:48]) >= -16384) && ($signed(m_tdata[63:48]) <= 16384))
        else $error("result component out of unit range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule
